FILE: rtl/mwr_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwr_pkg
// Shared types and codes for the maximum width ramp block.
// ----------------------------------------------------------------------------
package mwr_pkg;

    localparam int VALUE_W  = 32;
    localparam int LENGTH_W = 11;
    localparam int INDEX_W  = 10;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_TOO_FEW  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd2;
    localparam logic [STATUS_W-1:0] ST_TOO_MANY = 2'd3;

    typedef struct packed {
        logic signed [VALUE_W-1:0] sample_value;
        logic                      final_item;
    } sample_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [LENGTH_W-1:0] best_length;
        logic [INDEX_W-1:0]  start_index;
        logic [INDEX_W-1:0]  end_index;
        logic [LENGTH_W-1:0] pair_total;
        logic                list_truncated;
        logic                final_result;
    } result_t;

    // classified item handed from the front end to the search engine
    typedef struct packed {
        logic signed [VALUE_W-1:0] value;
        logic                      store;
        logic                      last;
        logic                      overflow;
    } q_entry_t;

endpackage

FILE: rtl/mwr_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwr_front
// Accepts items, tracks the fill level and marks stored or dropped values.
// ----------------------------------------------------------------------------
module mwr_front #(
    parameter int DEPTH = 1024
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              sample_valid,
    output logic              sample_ready,
    input  mwr_pkg::sample_t  sample,
    output logic              push_valid,
    input  logic              push_ready,
    output mwr_pkg::q_entry_t push_entry
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] fill_reg, fill_next;
    logic          ov_reg, ov_next;
    logic          accept;
    logic          store;

    assign sample_ready = push_ready;
    assign push_valid   = sample_valid;
    assign accept       = sample_valid && push_ready;
    assign store        = (fill_reg < CW'(DEPTH));

    always_comb
    begin
        push_entry.value    = sample.sample_value;
        push_entry.store    = store;
        push_entry.last     = sample.final_item;
        push_entry.overflow = ov_reg | ~store;
    end

    always_comb
    begin
        fill_next = fill_reg;
        ov_next   = ov_reg;
        if (accept)
        begin
            if (sample.final_item)
            begin
                fill_next = '0;
                ov_next   = 1'b0;
            end
            else
            begin
                fill_next = fill_reg + CW'(store);
                ov_next   = ov_reg | ~store;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
            ov_reg   <= 1'b0;
        end
        else
        begin
            fill_reg <= fill_next;
            ov_reg   <= ov_next;
        end
    end

endmodule

FILE: rtl/mwr_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwr_queue
// Two-entry queue between the front end and the search engine.
// ----------------------------------------------------------------------------
module mwr_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push_valid,
    output logic              push_ready,
    input  mwr_pkg::q_entry_t push_entry,
    output logic              pop_valid,
    input  logic              pop_ready,
    output mwr_pkg::q_entry_t pop_entry
);

    mwr_pkg::q_entry_t slot_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_entry  = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(push) - 2'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/mwr_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mwr_back
// Value store, ramp search sequencer, pair list and result register.
// ----------------------------------------------------------------------------
module mwr_back #(
    parameter int DEPTH     = 1024,
    parameter int MAX_PAIRS = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              q_valid,
    output logic              q_ready,
    input  mwr_pkg::q_entry_t q_entry,
    output logic              result_valid,
    input  logic              result_ready,
    output mwr_pkg::result_t  result
);

    localparam int CW  = $clog2(DEPTH + 1);
    localparam int IW  = $clog2(DEPTH);
    localparam int PMW = $clog2(MAX_PAIRS + 1);
    localparam int KW  = (CW > PMW) ? CW : PMW;
    localparam int PW  = (MAX_PAIRS > 1) ? $clog2(MAX_PAIRS) : 1;
    localparam logic [KW-1:0] MAXP = KW'(MAX_PAIRS);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CAPI  = 3'd1;
    localparam logic [2:0] S_CMP   = 3'd2;
    localparam logic [2:0] S_DONE  = 3'd3;
    localparam logic [2:0] S_PRD   = 3'd4;
    localparam logic [2:0] S_PLOAD = 3'd5;
    localparam logic [2:0] S_ERR   = 3'd6;

    logic signed [31:0] value_mem [DEPTH];
    logic [2*IW-1:0]    pair_mem  [MAX_PAIRS];

    logic [2:0]         state_reg, state_next;
    logic [CW-1:0]      wptr_reg, wptr_next;
    logic [CW-1:0]      n_reg, n_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic signed [31:0] vi_reg, vi_next;
    logic signed [31:0] rdata_reg;
    logic [CW-1:0]      best_reg, best_next;
    logic [KW-1:0]      cnt_reg, cnt_next;
    logic [PW-1:0]      k_reg, k_next;
    logic [1:0]         err_reg, err_next;
    logic [2*IW-1:0]    pair_rd_reg;
    logic               out_valid_reg, out_valid_next;
    mwr_pkg::result_t   out_reg, out_next;

    logic [IW-1:0]      rd_addr;
    logic               mem_we;
    logic               pair_we;
    logic [PW-1:0]      pair_waddr;
    logic [CW-1:0]      n_final;
    logic [CW-1:0]      span;
    logic [IW-1:0]      last_i;
    logic               step;
    logic               out_free;
    logic [KW-1:0]      emit;
    logic               pair_last;
    logic               pop;

    assign q_ready      = (state_reg == S_IDLE);
    assign pop          = q_valid && q_ready;
    assign mem_we       = pop && q_entry.store;
    assign n_final      = wptr_reg + CW'(q_entry.store);
    assign last_i       = IW'(n_reg - CW'(1));
    assign step         = (j_reg > i_reg) && (rdata_reg < vi_reg);
    assign span         = CW'(j_reg - i_reg) + CW'(1);
    assign out_free     = !out_valid_reg || result_ready;
    assign emit         = (cnt_reg < MAXP) ? cnt_reg : MAXP;
    assign pair_last    = ((KW'(k_reg) + KW'(1)) == emit);
    assign result_valid = out_valid_reg;
    assign result       = out_reg;

    always_comb
    begin
        state_next     = state_reg;
        wptr_next      = wptr_reg;
        n_next         = n_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        vi_next        = vi_reg;
        best_next      = best_reg;
        cnt_next       = cnt_reg;
        k_next         = k_reg;
        err_next       = err_reg;
        out_valid_next = out_valid_reg && !result_ready;
        out_next       = out_reg;
        rd_addr        = i_reg;
        pair_we        = 1'b0;
        pair_waddr     = '0;

        case (state_reg)
            S_IDLE:
            begin
                if (pop)
                begin
                    if (q_entry.last)
                    begin
                        wptr_next = '0;
                        n_next    = n_final;
                        i_next    = '0;
                        best_next = '0;
                        cnt_next  = '0;
                        rd_addr   = '0;
                        if (q_entry.overflow)
                        begin
                            err_next   = mwr_pkg::ST_TOO_MANY;
                            state_next = S_ERR;
                        end
                        else if (n_final < CW'(2))
                        begin
                            err_next   = mwr_pkg::ST_TOO_FEW;
                            state_next = S_ERR;
                        end
                        else
                        begin
                            state_next = S_CAPI;
                        end
                    end
                    else
                    begin
                        wptr_next = n_final;
                    end
                end
            end
            S_CAPI:
            begin
                vi_next    = rdata_reg;
                j_next     = last_i;
                rd_addr    = last_i;
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (step)
                begin
                    j_next  = j_reg - IW'(1);
                    rd_addr = j_reg - IW'(1);
                end
                else
                begin
                    if (span > best_reg)
                    begin
                        best_next  = span;
                        cnt_next   = KW'(1);
                        pair_we    = 1'b1;
                        pair_waddr = '0;
                    end
                    else if (span == best_reg)
                    begin
                        cnt_next = cnt_reg + KW'(1);
                        if (cnt_reg < MAXP)
                        begin
                            pair_we    = 1'b1;
                            pair_waddr = cnt_reg[PW-1:0];
                        end
                    end
                    if (i_reg == last_i)
                    begin
                        state_next = S_DONE;
                    end
                    else
                    begin
                        i_next     = i_reg + IW'(1);
                        rd_addr    = i_reg + IW'(1);
                        state_next = S_CAPI;
                    end
                end
            end
            S_DONE:
            begin
                k_next = '0;
                if (best_reg == CW'(1))
                begin
                    err_next   = mwr_pkg::ST_NOTFOUND;
                    state_next = S_ERR;
                end
                else
                begin
                    state_next = S_PRD;
                end
            end
            S_PRD:
            begin
                state_next = S_PLOAD;
            end
            S_PLOAD:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.status         = mwr_pkg::ST_OK;
                    out_next.best_length    = mwr_pkg::LENGTH_W'(best_reg);
                    out_next.start_index    = mwr_pkg::INDEX_W'(pair_rd_reg[2*IW-1:IW]);
                    out_next.end_index      = mwr_pkg::INDEX_W'(pair_rd_reg[IW-1:0]);
                    out_next.pair_total     = mwr_pkg::LENGTH_W'(cnt_reg);
                    out_next.list_truncated = (cnt_reg > MAXP);
                    out_next.final_result   = pair_last;
                    if (pair_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        k_next     = k_reg + PW'(1);
                        state_next = S_PRD;
                    end
                end
            end
            S_ERR:
            begin
                if (out_free)
                begin
                    out_valid_next          = 1'b1;
                    out_next.status         = err_reg;
                    out_next.best_length    = '0;
                    out_next.start_index    = '0;
                    out_next.end_index      = '0;
                    out_next.pair_total     = '0;
                    out_next.list_truncated = 1'b0;
                    out_next.final_result   = 1'b1;
                    state_next              = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            value_mem[wptr_reg[IW-1:0]] <= q_entry.value;
        end
        rdata_reg <= value_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (pair_we)
        begin
            pair_mem[pair_waddr] <= {i_reg, j_reg};
        end
        pair_rd_reg <= pair_mem[k_reg];
    end

    always_ff @(posedge clk)
    begin
        n_reg    <= n_next;
        i_reg    <= i_next;
        j_reg    <= j_next;
        vi_reg   <= vi_next;
        best_reg <= best_next;
        cnt_reg  <= cnt_next;
        k_reg    <= k_next;
        err_reg  <= err_next;
        out_reg  <= out_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            wptr_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wptr_reg      <= wptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

`ifndef ASSERT_OFF
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (j_reg >= i_reg && CW'(j_reg) < n_reg))
        else $error("end index scan left its range");

    a_best_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP || state_reg == S_DONE || state_reg == S_PLOAD)
        |-> (best_reg <= n_reg && KW'(best_reg) <= KW'(n_reg)
             && cnt_reg <= KW'(n_reg)))
        else $error("span or pair count exceeds value count");

    a_err_shape: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_reg.status != mwr_pkg::ST_OK)
        |-> (out_reg.final_result && out_reg.best_length == '0
             && out_reg.pair_total == '0))
        else $error("error item carries pair data");

    a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PLOAD && out_free) |=> (state_reg == S_IDLE || state_reg == S_PRD))
        else $error("result sequencing broken");
`endif

endmodule

FILE: rtl/max_width_ramp_all_ties_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// max_width_ramp_all_ties_top
// Maximum width ramp search reporting the maximal pairs, up to MAX_PAIRS of them.
// ----------------------------------------------------------------------------
// Values load at one item per cycle, while the search engine is idle, through a
// two-entry queue into the store. After the final item the search runs n start
// indices, each stepping its end index down past smaller values. Too few or too
// many values give the error item without a search. Pair results leave one at a
// time from the pair list; a not found item follows the search. Reset clears the
// control state only; the store is not swept or cleared.
// ----------------------------------------------------------------------------
module max_width_ramp_all_ties_top #(
    parameter int DEPTH     = 1024,
    parameter int MAX_PAIRS = 32
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             sample_valid,
    output logic             sample_ready,
    input  mwr_pkg::sample_t sample,
    output logic             result_valid,
    input  logic             result_ready,
    output mwr_pkg::result_t result
);

    logic              push_valid;
    logic              push_ready;
    mwr_pkg::q_entry_t push_entry;
    logic              pop_valid;
    logic              pop_ready;
    mwr_pkg::q_entry_t pop_entry;

    mwr_front #(
        .DEPTH (DEPTH)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .push_valid   (push_valid),
        .push_ready   (push_ready),
        .push_entry   (push_entry)
    );

    mwr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_entry (push_entry),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_entry  (pop_entry)
    );

    mwr_back #(
        .DEPTH     (DEPTH),
        .MAX_PAIRS (MAX_PAIRS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_valid      (pop_valid),
        .q_ready      (pop_ready),
        .q_entry      (pop_entry),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

endmodule

FILE: test/tb_max_width_ramp_all_ties_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_max_width_ramp_all_ties_top
// Self-checking bench for the all-ties maximum width ramp search.
// ----------------------------------------------------------------------------
// The bench first sends a short table of runs: the value extremes, a single
// value, a strictly falling pair, plain ramps and ramps with ties. It then
// sends random runs. These include tie-heavy runs, falling runs, runs with
// more pairs than the list holds, a run that fills the store exactly, and a
// run that overflows it. A behavioral model predicts every result that the table
// does not give. Each accepted result is compared field by field with the oldest
// expected result. Both handshakes idle at random.
// ----------------------------------------------------------------------------
module tb_max_width_ramp_all_ties_top;

    localparam int DEPTH       = 1024;
    localparam int MAX_PAIRS   = 32;
    localparam int PLAIN_ITEMS = 260;
    localparam int TAIL_CYCLES = 64;

    typedef enum int {
        RUN_RANDOM,
        RUN_TIES,
        RUN_DESCENDING,
        RUN_SINGLE,
        RUN_PAIRS,
        RUN_FULL,
        RUN_OVERFLOW
    } run_kind_t;

    typedef struct packed {
        mwr_pkg::sample_t item;
        bit               known;
        mwr_pkg::result_t want;
    } step_t;

    logic             clk          = 1'b0;
    logic             rst_n        = 1'b0;
    logic             sample_valid = 1'b0;
    logic             sample_ready;
    mwr_pkg::sample_t sample       = '0;
    logic             result_valid;
    logic             result_ready = 1'b0;
    mwr_pkg::result_t result;

    logic signed [mwr_pkg::VALUE_W-1:0] value_mem [DEPTH];
    int unsigned      fill_cnt       = 0;
    bit               store_overflow = 1'b0;
    mwr_pkg::result_t ramp_expect[$];
    mwr_pkg::result_t ramp_new[$];
    int unsigned      mismatch_count = 0;
    bit               sender_calm    = 1'b0;
    bit               sink_calm      = 1'b0;

    // known expectations: status, length, start, end, total, truncated, last
    step_t directed_steps [23] = '{
        '{'{32'sh7FFF_FFFF, 1'b1}, 1'b1,
          '{mwr_pkg::ST_TOO_FEW, 11'd0, 10'd0, 10'd0, 11'd0, 1'b0, 1'b1}},
        '{'{32'sh8000_0000, 1'b0}, 1'b0, '0},
        '{'{32'sh7FFF_FFFF, 1'b1}, 1'b1,
          '{mwr_pkg::ST_OK, 11'd2, 10'd0, 10'd1, 11'd1, 1'b0, 1'b1}},
        '{'{32'sh7FFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{32'sh8000_0000, 1'b1}, 1'b1,
          '{mwr_pkg::ST_NOTFOUND, 11'd0, 10'd0, 10'd0, 11'd0, 1'b0, 1'b1}},
        '{'{32'sh0000_0000, 1'b0}, 1'b0, '0},
        '{'{32'sh0000_0000, 1'b1}, 1'b0, '0},
        '{'{32'shFFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{32'shFFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{32'shFFFF_FFFF, 1'b1}, 1'b0, '0},
        '{'{32'sd5, 1'b0}, 1'b0, '0},
        '{'{32'sd3, 1'b0}, 1'b0, '0},
        '{'{32'sd4, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b1}, 1'b0, '0},
        '{'{32'sd2, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd2, 1'b0}, 1'b0, '0},
        '{'{32'sd1, 1'b1}, 1'b0, '0},
        '{'{32'sh8000_0000, 1'b1}, 1'b1,
          '{mwr_pkg::ST_TOO_FEW, 11'd0, 10'd0, 10'd0, 11'd0, 1'b0, 1'b1}},
        '{'{32'sd1, 1'b0}, 1'b0, '0},
        '{'{32'sd0, 1'b0}, 1'b0, '0},
        '{'{32'shFFFF_FFFF, 1'b0}, 1'b0, '0},
        '{'{32'sh8000_0000, 1'b1}, 1'b1,
          '{mwr_pkg::ST_NOTFOUND, 11'd0, 10'd0, 10'd0, 11'd0, 1'b0, 1'b1}}
    };

    max_width_ramp_all_ties_top #(
        .DEPTH     (DEPTH),
        .MAX_PAIRS (MAX_PAIRS)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .sample_valid (sample_valid),
        .sample_ready (sample_ready),
        .sample       (sample),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    initial
    begin
        #2_000_000;
        $display("simulation failed");
        $finish;
    end

    function automatic int unsigned idle_draw(input bit calm);
        return calm ? 0 : $urandom_range(0, 4);
    endfunction

    task automatic report(input string msg);
        $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    task automatic check_field(input string name, input logic [15:0] got,
                               input logic [15:0] want);
        if (got !== want)
            report($sformatf("%s got %0d want %0d", name, got, want));
    endtask

    // stores the value if the store has room; on the last value runs the ramp search into ramp_new
    function automatic void predict_ramp(input mwr_pkg::sample_t s);
        int unsigned      n, best, total, emit, span, i, j, k;
        int unsigned      start_at [MAX_PAIRS];
        int unsigned      end_at [MAX_PAIRS];
        bit               falling;
        mwr_pkg::result_t r;
        ramp_new.delete();
        if (fill_cnt < DEPTH)
        begin
            value_mem[fill_cnt] = s.sample_value;
            fill_cnt++;
        end
        else
            store_overflow = 1'b1;
        if (!s.final_item)
            return;
        n = fill_cnt;
        r = '0;
        r.final_result = 1'b1;
        falling = 1'b1;
        for (i = 0; i + 1 < n; i++)
            if (value_mem[i] <= value_mem[i + 1])
                falling = 1'b0;
        if (store_overflow)
        begin
            r.status = mwr_pkg::ST_TOO_MANY;
            ramp_new.push_back(r);
        end
        else if (n < 2)
        begin
            r.status = mwr_pkg::ST_TOO_FEW;
            ramp_new.push_back(r);
        end
        else if (falling)
        begin
            r.status = mwr_pkg::ST_NOTFOUND;
            ramp_new.push_back(r);
        end
        else
        begin
            best  = 0;
            total = 0;
            for (i = 0; i < n; i++)
            begin
                j = n - 1;
                while (j > i && value_mem[j] < value_mem[i])
                    j--;
                span = j - i + 1;
                if (span > best)
                begin
                    best  = span;
                    total = 0;
                end
                if (span == best)
                begin
                    if (total < MAX_PAIRS)
                    begin
                        start_at[total] = i;
                        end_at[total]   = j;
                    end
                    total++;
                end
            end
            emit = (total < MAX_PAIRS) ? total : MAX_PAIRS;
            for (k = 0; k < emit; k++)
            begin
                r.status         = mwr_pkg::ST_OK;
                r.best_length    = mwr_pkg::LENGTH_W'(best);
                r.start_index    = mwr_pkg::INDEX_W'(start_at[k]);
                r.end_index      = mwr_pkg::INDEX_W'(end_at[k]);
                r.pair_total     = mwr_pkg::LENGTH_W'(total);
                r.list_truncated = (total > MAX_PAIRS);
                r.final_result   = (k + 1 == emit);
                ramp_new.push_back(r);
            end
        end
        fill_cnt       = 0;
        store_overflow = 1'b0;
    endfunction

    task automatic send_sample(input mwr_pkg::sample_t s, input bit known,
                               input mwr_pkg::result_t want);
        int unsigned gap;
        if ($urandom_range(0, 19) == 0)
            sender_calm = !sender_calm;
        gap = idle_draw(sender_calm);
        if (gap != 0)
        begin
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample       <= s;
        sample_valid <= 1'b1;
        do @(posedge clk); while (sample_ready !== 1'b1);
        predict_ramp(s);
        if (known)
            ramp_expect.push_back(want);
        else
            foreach (ramp_new[k])
                ramp_expect.push_back(ramp_new[k]);
    endtask

    task automatic hold_until_drained();
        sample_valid <= 1'b0;
        @(posedge clk);
        while (ramp_expect.size() != 0)
            @(posedge clk);
    endtask

    // size is the value count, or the number of equal pairs for RUN_PAIRS
    task automatic send_run(input run_kind_t kind, input int unsigned size);
        logic signed [mwr_pkg::VALUE_W-1:0] vals[$];
        logic signed [mwr_pkg::VALUE_W-1:0] v;
        mwr_pkg::sample_t s;
        case (kind)
            RUN_RANDOM:
                repeat (size)
                begin
                    case ($urandom_range(0, 7))
                        0:       v = 32'sh8000_0000;
                        1:       v = 32'sh7FFF_FFFF;
                        default: v = $urandom;
                    endcase
                    vals.push_back(v);
                end
            RUN_TIES:
                repeat (size)
                    vals.push_back($signed($urandom_range(0, 4)) - 2);
            RUN_DESCENDING:
            begin
                v = $urandom_range(0, 2_000_000_000);
                repeat (size)
                begin
                    vals.push_back(v);
                    v = v - $urandom_range(1, 100_000_000);
                end
            end
            RUN_SINGLE:
                vals.push_back($urandom);
            RUN_PAIRS:
            begin
                v = 2_000_000_000 - $urandom_range(0, 1000);
                repeat (size)
                begin
                    vals.push_back(v);
                    vals.push_back(v);
                    v = v - $urandom_range(1, 1_000_000);
                end
            end
            RUN_FULL:
            begin
                v = 32'sh8000_0000 + $urandom_range(0, 1000);
                repeat (size)
                begin
                    vals.push_back(v);
                    v = v + $urandom_range(0, 1000);
                end
            end
            default:
                repeat (size)
                    vals.push_back($urandom);
        endcase
        foreach (vals[k])
        begin
            s.sample_value = vals[k];
            s.final_item   = (k == vals.size() - 1);
            send_sample(s, 1'b0, '0);
        end
    endtask

    initial
    begin
        int unsigned plain_items, run_no, pick, size;
        run_kind_t   kind;
        plain_items = 0;
        run_no      = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        foreach (directed_steps[k])
            send_sample(directed_steps[k].item, directed_steps[k].known,
                        directed_steps[k].want);
        hold_until_drained();

        while (plain_items < PLAIN_ITEMS)
        begin
            run_no++;
            case (run_no)
                3:  send_run(RUN_OVERFLOW, DEPTH + $urandom_range(1, 5));
                6:  send_run(RUN_FULL, DEPTH);
                9:  send_run(RUN_PAIRS, MAX_PAIRS + 1);
                12: send_run(RUN_PAIRS, MAX_PAIRS);
                15: send_run(RUN_PAIRS, MAX_PAIRS + $urandom_range(2, 8));
                default:
                begin
                    pick = $urandom_range(0, 9);
                    if (pick < 5)
                    begin
                        kind = RUN_RANDOM;
                        size = $urandom_range(2, 24);
                    end
                    else if (pick < 7)
                    begin
                        kind = RUN_TIES;
                        size = $urandom_range(2, 24);
                    end
                    else if (pick == 7)
                    begin
                        kind = RUN_DESCENDING;
                        size = $urandom_range(2, 12);
                    end
                    else if (pick == 8)
                    begin
                        kind = RUN_SINGLE;
                        size = 1;
                    end
                    else
                    begin
                        kind = RUN_PAIRS;
                        size = $urandom_range(1, 6);
                    end
                    send_run(kind, size);
                    plain_items += (kind == RUN_PAIRS) ? 2 * size : size;
                end
            endcase
            if ($urandom_range(0, 4) == 0)
                hold_until_drained();
        end

        hold_until_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        int unsigned      stall;
        mwr_pkg::result_t want;
        stall = 0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (result_valid === 1'b1 && result_ready)
            begin
                if (ramp_expect.size() == 0)
                    report($sformatf("unexpected item status %0d start %0d end %0d",
                                     result.status, result.start_index, result.end_index));
                else
                begin
                    want = ramp_expect.pop_front();
                    check_field("status", 16'(result.status), 16'(want.status));
                    check_field("best_length", 16'(result.best_length),
                                16'(want.best_length));
                    check_field("start_index", 16'(result.start_index),
                                16'(want.start_index));
                    check_field("end_index", 16'(result.end_index), 16'(want.end_index));
                    check_field("pair_total", 16'(result.pair_total),
                                16'(want.pair_total));
                    check_field("list_truncated", 16'(result.list_truncated),
                                16'(want.list_truncated));
                    check_field("final_result", 16'(result.final_result),
                                16'(want.final_result));
                end
                if ($urandom_range(0, 19) == 0)
                    sink_calm = !sink_calm;
                stall = idle_draw(sink_calm);
            end
            if (stall != 0)
            begin
                result_ready <= 1'b0;
                stall--;
            end
            else
                result_ready <= 1'b1;
        end
    end

endmodule

FILE: files.f
rtl/mwr_pkg.sv
rtl/mwr_front.sv
rtl/mwr_queue.sv
rtl/mwr_back.sv
rtl/max_width_ramp_all_ties_top.sv
test/tb_max_width_ramp_all_ties_top.sv
